// ===== hw/rtl/dpas_pkg.sv =====
package dpas_pkg;

  // Tick rate and default timing of the two jobs.
  localparam logic [31:0] TICKS_PER_SECOND = 32'd32768;
  localparam logic [31:0] PERIOD_A_SECONDS = 32'd30;
  localparam logic [31:0] PERIOD_B_SECONDS = 32'd60;
  localparam logic [31:0] GAP_SECONDS      = 32'd10;

  localparam logic [31:0] PERIOD_A_RESET = 32'(PERIOD_A_SECONDS * TICKS_PER_SECOND);
  localparam logic [31:0] PERIOD_B_RESET = 32'(PERIOD_B_SECONDS * TICKS_PER_SECOND);
  localparam logic [31:0] GAP_RESET      = 32'(GAP_SECONDS * TICKS_PER_SECOND);

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_A = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_B = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP      = 2'd2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WAKE  = 2'd1,
    OP_DONE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_A    = 2'd1,
    JOB_B    = 2'd2
  } job_e;

  typedef enum logic [1:0] {
    PEND_NONE     = 2'd0,
    PEND_A        = 2'd1,
    PEND_B        = 2'd2,
    PEND_A_THEN_B = 2'd3
  } pend_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  run_job;
    logic        alarm_set;
    logic [31:0] alarm_time;
    logic        error;
  } out_req_t;

  // Status of the shared remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/dual_periodic_alarm_scheduler.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o  in_req_i   (operation, now)
// out       output     out_valid_o/out_stall_i out_req_o (run_job, alarm_set, alarm_time, error)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One request is handled at a time. A start, a wake or an ignored request passes from
// acceptance through evaluation to the response state, which loads its result, and the
// next request is taken once the block is idle again. A run-done request also runs a
// catch-up on job A's due time and, after a single pending job, on job B's, each only
// if that due time is not ahead of now; each catch-up occupies the shared remainder unit.
// Reset clears the schedule and loads the default periods; no clearing pass is needed.
// A stalled output holds its result, and a finished result waits, with in_stall_o
// high, until the previous one has left.
module dual_periodic_alarm_scheduler import dpas_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_req_t                in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_req_t               out_req_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  // Arithmetic width: wide enough for both the tick time and a 32-bit period.
  localparam int unsigned CalcWidth = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVAL = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] period_a_q, period_b_q, gap_q;

  logic [TIME_WIDTH-1:0] due_a_q, due_a_d;
  logic [TIME_WIDTH-1:0] due_b_q, due_b_d;
  logic                  gap_wait_q, gap_wait_d;
  pend_e                 pend_q, pend_d;
  logic                  started_q, started_d;

  // The request under work and its pending result.
  logic [1:0]            op_q, op_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic                  sel_b_q, sel_b_d;   // catch-up works on job B
  logic                  both_q, both_d;     // catch-up covers both jobs
  logic [1:0]            res_job_q, res_job_d;
  logic                  res_set_q, res_set_d;
  logic [TIME_WIDTH-1:0] res_time_q, res_time_d;
  logic                  res_err_q, res_err_d;
  logic                  res_min_q, res_min_d; // alarm is the earlier due time

  logic     out_valid_q, out_valid_d;
  out_req_t out_q, out_d;

  logic [CalcWidth-1:0]  now_in_ext;
  logic [CalcWidth-1:0]  eff_pa, eff_pb, gap_ext, eff_sel;
  logic [TIME_WIDTH-1:0] gap_w;
  logic [TIME_WIDTH-1:0] cur_due, earliest, catch_due;
  logic [CalcWidth-1:0]  catch_sum, res_time_ext;
  logic                  cur_late;

  logic                  div_start;
  logic [CalcWidth-1:0]  div_rem;
  div_stat_t             div_stat;

  // A period of zero counts as one tick.
  assign eff_pa  = CalcWidth'((period_a_q == '0) ? 32'd1 : period_a_q);
  assign eff_pb  = CalcWidth'((period_b_q == '0) ? 32'd1 : period_b_q);
  assign gap_ext = CalcWidth'(gap_q);
  assign gap_w   = gap_ext[TIME_WIDTH-1:0];

  // Raw periods for plain advances; a zero period only matters to catch-up,
  // so the plain adds below use the written value itself.
  logic [CalcWidth-1:0]  raw_pa, raw_pb;
  logic [TIME_WIDTH-1:0] raw_pa_w, raw_pb_w;
  assign raw_pa   = CalcWidth'(period_a_q);
  assign raw_pb   = CalcWidth'(period_b_q);
  assign raw_pa_w = raw_pa[TIME_WIDTH-1:0];
  assign raw_pb_w = raw_pb[TIME_WIDTH-1:0];

  assign now_in_ext = CalcWidth'(in_req_i.now);
  assign earliest   = (due_a_q < due_b_q) ? due_a_q : due_b_q;

  // Catch-up of one due time. With r the remainder of (now - due) by the period,
  // the smallest due + k*period beyond now equals now - r + period.
  assign cur_due   = sel_b_q ? due_b_q : due_a_q;
  assign eff_sel   = sel_b_q ? eff_pb : eff_pa;
  assign cur_late  = (cur_due <= now_q);
  assign div_start = (state_q == ST_CHK) && cur_late;
  assign catch_sum = CalcWidth'(now_q) - div_rem + eff_sel;
  assign catch_due = catch_sum[TIME_WIDTH-1:0];

  dpas_rem_unit #(
    .DvdWidth(TIME_WIDTH),
    .DsrWidth(CalcWidth)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(now_q - cur_due),
    .divisor_i (eff_sel),
    .stat_o    (div_stat),
    .rem_o     (div_rem)
  );

  assign res_time_ext = CalcWidth'(res_min_q ? earliest : res_time_q);

  always_comb begin
    state_d     = state_q;
    due_a_d     = due_a_q;
    due_b_d     = due_b_q;
    gap_wait_d  = gap_wait_q;
    pend_d      = pend_q;
    started_d   = started_q;
    op_d        = op_q;
    now_d       = now_q;
    sel_b_d     = sel_b_q;
    both_d      = both_q;
    res_job_d   = res_job_q;
    res_set_d   = res_set_q;
    res_time_d  = res_time_q;
    res_err_d   = res_err_q;
    res_min_d   = res_min_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_req_i.operation;
          now_d   = now_in_ext[TIME_WIDTH-1:0];
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        res_job_d  = JOB_NONE;
        res_set_d  = 1'b0;
        res_time_d = '0;
        res_err_d  = 1'b0;
        res_min_d  = 1'b0;
        sel_b_d    = 1'b0;
        both_d     = 1'b0;
        state_d    = ST_RESP;
        case (op_q)
          OP_START: begin
            due_a_d    = now_q + raw_pa_w;
            due_b_d    = now_q + raw_pb_w;
            gap_wait_d = 1'b0;
            pend_d     = PEND_NONE;
            started_d  = 1'b1;
            res_set_d  = 1'b1;
            res_time_d = now_q + raw_pa_w;
          end
          OP_WAKE: begin
            if (started_q && pend_q == PEND_NONE) begin
              if (gap_wait_q) begin
                gap_wait_d = 1'b0;
                pend_d     = PEND_B;
                res_job_d  = JOB_B;
              end else if (now_q >= due_a_q && now_q >= due_b_q) begin
                pend_d    = PEND_A_THEN_B;
                res_job_d = JOB_A;
              end else if (now_q >= due_a_q) begin
                pend_d    = PEND_A;
                res_job_d = JOB_A;
              end else if (now_q >= due_b_q) begin
                pend_d    = PEND_B;
                res_job_d = JOB_B;
              end else begin
                // Both due times are already ahead of now: nothing to catch up.
                res_set_d = 1'b1;
                res_min_d = 1'b1;
              end
            end else begin
              res_err_d = 1'b1;
            end
          end
          OP_DONE: begin
            if (started_q && pend_q != PEND_NONE) begin
              pend_d  = PEND_NONE;
              state_d = ST_CHK;
              case (pend_q)
                PEND_A_THEN_B: begin
                  due_a_d    = due_a_q + raw_pa_w;
                  gap_wait_d = 1'b1;
                  res_set_d  = 1'b1;
                  res_time_d = now_q + gap_w;
                end
                PEND_A: begin
                  due_a_d   = due_a_q + raw_pa_w;
                  both_d    = 1'b1;
                  res_set_d = 1'b1;
                  res_min_d = 1'b1;
                end
                default: begin
                  due_b_d   = due_b_q + raw_pb_w;
                  both_d    = 1'b1;
                  res_set_d = 1'b1;
                  res_min_d = 1'b1;
                end
              endcase
            end else begin
              res_err_d = 1'b1;
            end
          end
          default: begin
            res_err_d = 1'b1;
          end
        endcase
      end

      ST_CHK: begin
        if (cur_late) begin
          state_d = ST_DIV;
        end else if (!sel_b_q && both_q) begin
          sel_b_d = 1'b1;
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_DIV: begin
        if (div_stat.done) begin
          if (sel_b_q) begin
            due_b_d = catch_due;
          end else begin
            due_a_d = catch_due;
          end
          if (!sel_b_q && both_q) begin
            sel_b_d = 1'b1;
            state_d = ST_CHK;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.run_job        = res_job_q;
          out_d.alarm_set      = res_set_q;
          out_d.alarm_time     = res_set_q ? res_time_ext[31:0] : 32'd0;
          out_d.error          = res_err_q;
          state_d              = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_a_q <= PERIOD_A_RESET;
      period_b_q <= PERIOD_B_RESET;
      gap_q      <= GAP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PERIOD_A: period_a_q <= cfg_data_i;
        CFG_PERIOD_B: period_b_q <= cfg_data_i;
        CFG_GAP:      gap_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      due_a_q     <= '0;
      due_b_q     <= '0;
      gap_wait_q  <= 1'b0;
      pend_q      <= PEND_NONE;
      started_q   <= 1'b0;
      sel_b_q     <= 1'b0;
      both_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      due_a_q     <= due_a_d;
      due_b_q     <= due_b_d;
      gap_wait_q  <= gap_wait_d;
      pend_q      <= pend_d;
      started_q   <= started_d;
      sel_b_q     <= sel_b_d;
      both_q      <= both_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    now_q      <= now_d;
    res_job_q  <= res_job_d;
    res_set_q  <= res_set_d;
    res_time_q <= res_time_d;
    res_err_q  <= res_err_d;
    res_min_q  <= res_min_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign cfg_ready_o = 1'b1;

  // The sequencer register always holds exactly one active state.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("scheduler state is not one-hot");

  // An accepted request always moves the sequencer into evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_EVAL))
    else $error("accepted request did not enter evaluation");

  // A job can only be pending once the schedule has been started.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != PEND_NONE) |-> started_q)
    else $error("job pending before start");

  // While the gap alarm is armed, no job is outstanding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_wait_q |-> (pend_q == PEND_NONE))
    else $error("gap wait overlaps a pending job");

  // The remainder unit is only busy while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == ST_DIV))
    else $error("remainder unit running outside catch-up");

  // An ignored request reports nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.error) |->
      (!out_req_o.alarm_set && out_req_o.run_job == JOB_NONE))
    else $error("error result carries a job or an alarm");

endmodule

// ===== hw/rtl/dpas_rem_unit.sv =====
// Restoring division that keeps only the remainder, one quotient bit per cycle.
module dpas_rem_unit import dpas_pkg::*; #(
  parameter int unsigned DvdWidth = 32,
  parameter int unsigned DsrWidth = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DvdWidth-1:0] dividend_i,
  input  logic [DsrWidth-1:0] divisor_i,
  output div_stat_t           stat_o,
  output logic [DsrWidth-1:0] rem_o
);

  localparam int unsigned CntWidth = $clog2(DvdWidth + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic [DvdWidth-1:0] dvd_q, dvd_d;
  logic [DsrWidth-1:0] dsr_q, dsr_d;
  logic [DsrWidth-1:0] rem_q, rem_d;
  logic [DsrWidth:0]   trial;

  assign trial = {rem_q, dvd_q[DvdWidth-1]};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    count_d = count_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    if (start_i && !busy_q) begin
      busy_d  = 1'b1;
      count_d = CntWidth'(DvdWidth);
      dvd_d   = dividend_i;
      dsr_d   = divisor_i;
      rem_d   = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DsrWidth'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[DsrWidth-1:0];
      end
      dvd_d   = {dvd_q[DvdWidth-2:0], 1'b0};
      count_d = count_q - CntWidth'(1);
      if (count_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule
